### src/byte_ring_buffer_threshold_macros.svh
// ----------------------------------------------------------------------------
// Byte ring buffer assertion macros
// Concurrent check macros shared by the RTL files of the byte ring buffer.
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_BUFFER_THRESHOLD_MACROS_SVH
`define BYTE_RING_BUFFER_THRESHOLD_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on the rising clock edge.
`define BRBT_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("brbt implication check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define BRBT_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("brbt next-cycle check failed");

`else

`define BRBT_ASSERT_IMPL(name, clk, rst, ante, cons)
`define BRBT_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

### src/brbt_pkg.sv
// ----------------------------------------------------------------------------
// Byte ring buffer package
// Sizes, command and status codes, shared record types and index helper.
// ----------------------------------------------------------------------------
package brbt_pkg;

   // Storage size and derived widths.
   localparam int CAPACITY = 65536;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int OCC_W    = 17;
   localparam int CMD_W    = 3;
   localparam int LEN_W    = 24;
   localparam int GMAX_W   = 7;
   localparam int STAT_W   = 3;
   localparam int TOTAL_W  = 32;
   localparam int MAX_GET  = 64;

   localparam logic [OCC_W-1:0] THR_RESET = OCC_W'(4096);

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_PUT    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_GET    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_CLOSE  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_REOPEN = 3'd3;
   localparam logic [CMD_W-1:0] CMD_POLL   = 3'd4;

   // Status codes.
   localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
   localparam logic [STAT_W-1:0] ST_DROPPED     = 3'd1;
   localparam logic [STAT_W-1:0] ST_REJECTED    = 3'd2;
   localparam logic [STAT_W-1:0] ST_NOT_CLOSED  = 3'd3;
   localparam logic [STAT_W-1:0] ST_TRIGGER     = 3'd4;
   localparam logic [STAT_W-1:0] ST_CLOSE_DATA  = 3'd5;
   localparam logic [STAT_W-1:0] ST_CLOSE_EMPTY = 3'd6;
   localparam logic [STAT_W-1:0] ST_EMPTY       = 3'd7;

   // Buffer state as reported in every result.
   typedef struct packed {
      logic [OCC_W-1:0]   used;
      logic [OCC_W-1:0]   peak;
      logic [TOTAL_W-1:0] put_total;
      logic [TOTAL_W-1:0] drop_total;
      logic [TOTAL_W-1:0] consume_total;
      logic               thr_reached;
      logic               closed;
   } stat_type;

   // One result record.
   typedef struct packed {
      logic [7:0]        out_byte;
      logic              byte_valid;
      logic              last;
      logic [STAT_W-1:0] status;
      stat_type          stat;
   } result_type;

   // Request from the command core to the read sequencer.
   typedef struct packed {
      logic              start;
      logic [GMAX_W-1:0] count;
   } get_job_type;

   // Read sequencer status back to the command core.
   typedef struct packed {
      logic can_take;
   } out_ctl_type;

   // Ring index advance with wrap at the store size.
   function automatic logic [ADDR_W-1:0] next_index(input logic [ADDR_W-1:0] idx);
      logic [ADDR_W-1:0] nxt;
      if (idx == ADDR_W'(CAPACITY - 1)) begin
         nxt = '0;
      end else begin
         nxt = idx + ADDR_W'(1);
      end
      return nxt;
   endfunction

endpackage

### src/brbt_req_if.sv
// ----------------------------------------------------------------------------
// Byte ring buffer request channel
// Valid/ready channel carrying one command transaction.
// ----------------------------------------------------------------------------
interface brbt_req_if;
   import brbt_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [7:0]        data_byte;
   logic              chunk_start;
   logic [LEN_W-1:0]  chunk_length;
   logic [GMAX_W-1:0] get_max;

   modport source (
      output valid, command, data_byte, chunk_start, chunk_length, get_max,
      input  ready
   );

   modport sink (
      input  valid, command, data_byte, chunk_start, chunk_length, get_max,
      output ready
   );

endinterface

### src/brbt_rsp_if.sv
// ----------------------------------------------------------------------------
// Byte ring buffer response channel
// Valid/ready channel carrying one result transaction.
// ----------------------------------------------------------------------------
interface brbt_rsp_if;
   import brbt_pkg::*;

   logic               valid;
   logic               ready;
   logic [7:0]         out_byte;
   logic               byte_valid;
   logic               last;
   logic [STAT_W-1:0]  status;
   logic [OCC_W-1:0]   used_count;
   logic [OCC_W-1:0]   max_used;
   logic [TOTAL_W-1:0] total_put_count;
   logic [TOTAL_W-1:0] dropped_count;
   logic [TOTAL_W-1:0] consumed_count;
   logic               threshold_reached;
   logic               closed_now;

   modport source (
      output valid, out_byte, byte_valid, last, status, used_count, max_used,
             total_put_count, dropped_count, consumed_count, threshold_reached,
             closed_now,
      input  ready
   );

   modport sink (
      input  valid, out_byte, byte_valid, last, status, used_count, max_used,
             total_put_count, dropped_count, consumed_count, threshold_reached,
             closed_now,
      output ready
   );

endinterface

### src/brbt_ram.sv
// ----------------------------------------------------------------------------
// Byte ring buffer storage
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module brbt_ram #(
   parameter int DEPTH = 65536,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data register holds its value while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/brbt_core.sv
// ----------------------------------------------------------------------------
// Byte ring buffer command core
// Decodes commands, owns the buffer state and counters, writes put bytes
// into the store and hands get transactions to the read sequencer.
// ----------------------------------------------------------------------------
`include "byte_ring_buffer_threshold_macros.svh"

module brbt_core import brbt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   brbt_req_if.sink          req_chan,
   input  logic              csr_wr_en,
   input  logic [OCC_W-1:0]  csr_wr_data,
   input  out_ctl_type       out_ctl,
   output result_type        cmd_result,
   output logic              cmd_load,
   output get_job_type       get_job,
   output stat_type          stat_now,
   output logic              ram_wr_en,
   output logic [ADDR_W-1:0] ram_wr_addr,
   output logic [7:0]        ram_wr_data
);

   typedef enum logic [3:0] {
      CHUNK_NONE   = 4'b0001,
      CHUNK_ADMIT  = 4'b0010,
      CHUNK_DROP   = 4'b0100,
      CHUNK_REJECT = 4'b1000
   } chunk_mode_type;

   localparam logic [OCC_W-1:0]  CAP_OCC = OCC_W'(CAPACITY);
   localparam logic [LEN_W-1:0]  CAP_LEN = LEN_W'(CAPACITY);
   localparam logic [GMAX_W-1:0] GET_LIM = GMAX_W'(MAX_GET);

   // State registers.
   logic [ADDR_W-1:0]  wptr_ff, wptr_in;
   logic [OCC_W-1:0]   occ_ff, occ_in;
   logic [OCC_W-1:0]   peak_ff, peak_in;
   logic               closed_ff, closed_in;
   logic [TOTAL_W-1:0] put_ff, put_in;
   logic [TOTAL_W-1:0] drop_ff, drop_in;
   logic [TOTAL_W-1:0] consume_ff, consume_in;
   chunk_mode_type     mode_ff, mode_in;
   logic [OCC_W-1:0]   remaining_ff, remaining_in;
   logic [OCC_W-1:0]   thr_ff;

   logic               req_fire;
   logic [OCC_W-1:0]   free_now;
   logic [LEN_W-1:0]   clip_len;
   logic [GMAX_W-1:0]  gmax_clip;
   logic [GMAX_W-1:0]  get_n;
   logic               store_req;
   logic               store_ok;
   logic [STAT_W-1:0]  status;

   assign req_chan.ready = out_ctl.can_take;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign free_now       = CAP_OCC - occ_ff;

   // Chunk length clipped to one at the bottom and to the store size on top.
   always_comb begin
      clip_len = req_chan.chunk_length;
      if (clip_len == '0) begin
         clip_len = LEN_W'(1);
      end
      if (clip_len > CAP_LEN) begin
         clip_len = CAP_LEN;
      end
   end

   // Number of bytes a get returns.
   always_comb begin
      gmax_clip = (req_chan.get_max > GET_LIM) ? GET_LIM : req_chan.get_max;
      if (occ_ff < OCC_W'(gmax_clip)) begin
         get_n = occ_ff[GMAX_W-1:0];
      end else begin
         get_n = gmax_clip;
      end
   end

   // Command decode and next state.
   always_comb begin
      wptr_in      = wptr_ff;
      occ_in       = occ_ff;
      peak_in      = peak_ff;
      closed_in    = closed_ff;
      put_in       = put_ff;
      drop_in      = drop_ff;
      consume_in   = consume_ff;
      mode_in      = mode_ff;
      remaining_in = remaining_ff;
      store_req    = 1'b0;
      status       = ST_OK;
      cmd_load     = 1'b0;
      get_job      = '0;

      if (req_fire) begin
         cmd_load = 1'b1;
         case (req_chan.command)
            CMD_PUT: begin
               if (req_chan.chunk_start) begin
                  if (closed_ff) begin
                     mode_in      = CHUNK_REJECT;
                     remaining_in = '0;
                     status       = ST_REJECTED;
                  end else if (LEN_W'(free_now) < clip_len) begin
                     mode_in      = CHUNK_DROP;
                     remaining_in = '0;
                     status       = ST_DROPPED;
                     drop_in      = drop_ff + TOTAL_W'(req_chan.chunk_length);
                  end else begin
                     mode_in      = CHUNK_ADMIT;
                     store_req    = 1'b1;
                     remaining_in = OCC_W'(clip_len - LEN_W'(1));
                  end
               end else begin
                  case (mode_ff)
                     CHUNK_ADMIT: begin
                        if (remaining_ff != '0) begin
                           store_req    = 1'b1;
                           remaining_in = remaining_ff - OCC_W'(1);
                        end
                     end
                     CHUNK_DROP:   status = ST_DROPPED;
                     CHUNK_REJECT: status = ST_REJECTED;
                     default:      status = ST_OK;
                  endcase
               end
            end
            CMD_GET: begin
               if (get_n == '0) begin
                  status = (occ_ff == '0) ? ST_EMPTY : ST_OK;
               end else begin
                  cmd_load      = 1'b0;
                  get_job.start = 1'b1;
                  get_job.count = get_n;
                  occ_in        = occ_ff - OCC_W'(get_n);
                  consume_in    = consume_ff + TOTAL_W'(get_n);
               end
            end
            CMD_CLOSE: begin
               closed_in = 1'b1;
            end
            CMD_REOPEN: begin
               if (!closed_ff) begin
                  status = ST_NOT_CLOSED;
               end else begin
                  closed_in = 1'b0;
               end
            end
            CMD_POLL: begin
               if (closed_ff) begin
                  status = (occ_ff != '0) ? ST_CLOSE_DATA : ST_CLOSE_EMPTY;
               end else if (occ_ff >= thr_ff || occ_ff != '0) begin
                  status = ST_TRIGGER;
               end else begin
                  status = ST_EMPTY;
               end
            end
            default: begin
               status = ST_OK;
            end
         endcase
      end

      // Byte store; a full store discards the byte.
      store_ok = store_req && (occ_ff != CAP_OCC);
      if (store_ok) begin
         wptr_in = next_index(wptr_ff);
         occ_in  = occ_ff + OCC_W'(1);
         put_in  = put_ff + TOTAL_W'(1);
         if (occ_ff + OCC_W'(1) > peak_ff) begin
            peak_in = occ_ff + OCC_W'(1);
         end
      end
   end

   // Store write port.
   assign ram_wr_en   = store_ok;
   assign ram_wr_addr = wptr_ff;
   assign ram_wr_data = req_chan.data_byte;

   // Single result of a non-streaming command, showing the state after it.
   always_comb begin
      cmd_result                    = '0;
      cmd_result.last               = 1'b1;
      cmd_result.status             = status;
      cmd_result.stat.used          = occ_in;
      cmd_result.stat.peak          = peak_in;
      cmd_result.stat.put_total     = put_in;
      cmd_result.stat.drop_total    = drop_in;
      cmd_result.stat.consume_total = consume_in;
      cmd_result.stat.thr_reached   = (occ_in >= thr_ff);
      cmd_result.stat.closed        = closed_in;
   end

   // Current state, used by the read sequencer for streamed get results.
   always_comb begin
      stat_now.used          = occ_ff;
      stat_now.peak          = peak_ff;
      stat_now.put_total     = put_ff;
      stat_now.drop_total    = drop_ff;
      stat_now.consume_total = consume_ff;
      stat_now.thr_reached   = (occ_ff >= thr_ff);
      stat_now.closed        = closed_ff;
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff      <= '0;
         occ_ff       <= '0;
         peak_ff      <= '0;
         closed_ff    <= 1'b0;
         put_ff       <= '0;
         drop_ff      <= '0;
         consume_ff   <= '0;
         mode_ff      <= CHUNK_NONE;
         remaining_ff <= '0;
      end else begin
         wptr_ff      <= wptr_in;
         occ_ff       <= occ_in;
         peak_ff      <= peak_in;
         closed_ff    <= closed_in;
         put_ff       <= put_in;
         drop_ff      <= drop_in;
         consume_ff   <= consume_in;
         mode_ff      <= mode_in;
         remaining_ff <= remaining_in;
      end
   end

   // Threshold register.
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   // The peak never falls below the current fill level.
   `BRBT_ASSERT_IMPL(a_peak_covers_used, clock, reset, 1'b1, peak_ff >= occ_ff)
   // An admitted chunk always has its remaining bytes reserved in free space.
   `BRBT_ASSERT_IMPL(a_chunk_space_reserved, clock, reset, mode_ff == CHUNK_ADMIT, free_now >= remaining_ff)
   // A chunk started while closed leaves the chunk in the rejected mode.
   `BRBT_ASSERT_NEXT(a_closed_put_rejected, clock, reset, req_fire && req_chan.command == CMD_PUT && req_chan.chunk_start && closed_ff, mode_ff == CHUNK_REJECT)

endmodule

### src/brbt_out.sv
// ----------------------------------------------------------------------------
// Byte ring buffer read sequencer and response register
// Streams get bytes out of the store one read a cycle while the sink keeps up
// and holds the result transaction in an output register until it is taken.
// ----------------------------------------------------------------------------
`include "byte_ring_buffer_threshold_macros.svh"

module brbt_out import brbt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   brbt_rsp_if.source        rsp_chan,
   input  result_type        cmd_result,
   input  logic              cmd_load,
   input  get_job_type       get_job,
   input  stat_type          stat_now,
   output out_ctl_type       out_ctl,
   output logic              ram_rd_en,
   output logic [ADDR_W-1:0] ram_rd_addr,
   input  logic [7:0]        ram_rd_data
);

   logic [ADDR_W-1:0] rptr_ff, rptr_in;
   logic [GMAX_W-1:0] rem_ff, rem_in;
   logic [GMAX_W-1:0] left_ff, left_in;
   logic              pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_data_ff, rsp_data_in;

   logic              slot_free;
   logic              load_get;
   logic              issue;
   logic [GMAX_W-1:0] pend_ext;
   result_type        get_record;

   // The output register is free when empty or being emptied this cycle.
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   // A fetched byte moves into the output register when there is room.
   assign load_get  = pend_ff && slot_free;
   // A read is issued only when the read data register will not be overwritten
   // while still holding a byte.
   assign issue     = (rem_ff != '0) && (!pend_ff || load_get);
   assign pend_ext  = GMAX_W'(pend_ff);

   assign ram_rd_en   = issue;
   assign ram_rd_addr = rptr_ff;

   assign out_ctl.can_take = (rem_ff == '0) && !pend_ff && slot_free;

   // Streamed get result.
   always_comb begin
      get_record            = '0;
      get_record.out_byte   = ram_rd_data;
      get_record.byte_valid = 1'b1;
      get_record.last       = (left_ff == GMAX_W'(1));
      get_record.status     = ST_OK;
      get_record.stat       = stat_now;
   end

   // Sequencer counters and output handshake.
   always_comb begin
      rem_in       = rem_ff;
      left_in      = left_ff;
      rptr_in      = rptr_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (get_job.start) begin
         rem_in  = get_job.count;
         left_in = get_job.count;
      end else begin
         if (issue) begin
            rem_in  = rem_ff - GMAX_W'(1);
            rptr_in = next_index(rptr_ff);
         end
         if (load_get) begin
            left_in = left_ff - GMAX_W'(1);
         end
      end

      if (issue) begin
         pend_in = 1'b1;
      end else if (load_get) begin
         pend_in = 1'b0;
      end

      if (load_get) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = get_record;
      end else if (cmd_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = cmd_result;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rptr_ff      <= '0;
         rem_ff       <= '0;
         left_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rptr_ff      <= rptr_in;
         rem_ff       <= rem_in;
         left_ff      <= left_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.out_byte          = rsp_data_ff.out_byte;
   assign rsp_chan.byte_valid        = rsp_data_ff.byte_valid;
   assign rsp_chan.last              = rsp_data_ff.last;
   assign rsp_chan.status            = rsp_data_ff.status;
   assign rsp_chan.used_count        = rsp_data_ff.stat.used;
   assign rsp_chan.max_used          = rsp_data_ff.stat.peak;
   assign rsp_chan.total_put_count   = rsp_data_ff.stat.put_total;
   assign rsp_chan.dropped_count     = rsp_data_ff.stat.drop_total;
   assign rsp_chan.consumed_count    = rsp_data_ff.stat.consume_total;
   assign rsp_chan.threshold_reached = rsp_data_ff.stat.thr_reached;
   assign rsp_chan.closed_now        = rsp_data_ff.stat.closed;

   // Bytes still to emit equal reads still to issue plus the fetched byte.
   `BRBT_ASSERT_IMPL(a_emit_matches_reads, clock, reset, 1'b1, left_ff == rem_ff + pend_ext)
   // An issued read always lands in the read data register next cycle.
   `BRBT_ASSERT_NEXT(a_read_lands, clock, reset, issue, pend_ff)
   // The final streamed byte of a get carries the last flag.
   `BRBT_ASSERT_NEXT(a_last_on_final, clock, reset, load_get && left_ff == GMAX_W'(1),
                     rsp_valid_ff && rsp_data_ff.last)

endmodule

### src/byte_ring_buffer_threshold.sv
// ----------------------------------------------------------------------------
// Byte ring buffer with chunk admission and fill threshold
// Top level: command core, 64 KiB byte store and read sequencer.
// ----------------------------------------------------------------------------
// Put, close, reopen, poll and unused commands each give one result
// transaction, so with a ready sink one such command is taken every cycle.
// A get that returns n bytes (n up to 64) occupies the block until its last
// byte is in the output register. The byte store has a single, registered
// read port, so each byte passes the read data register and then the output
// register; bytes follow one per cycle while the sink is ready. The store
// needs no clearing after reset; the threshold register may be written at
// any time the block is idle.

module byte_ring_buffer_threshold import brbt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   brbt_req_if.sink         req_chan,
   brbt_rsp_if.source       rsp_chan,
   input  logic             csr_wr_en,
   input  logic [OCC_W-1:0] csr_wr_data
);

   result_type        cmd_result;
   logic              cmd_load;
   get_job_type       get_job;
   stat_type          stat_now;
   out_ctl_type       out_ctl;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [7:0]        ram_wr_data;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [7:0]        ram_rd_data;

   // Command decode and buffer state.
   brbt_core u_core (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .out_ctl     (out_ctl),
      .cmd_result  (cmd_result),
      .cmd_load    (cmd_load),
      .get_job     (get_job),
      .stat_now    (stat_now),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data)
   );

   // Byte store.
   brbt_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (8)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Get streaming and response register.
   brbt_out u_out (
      .clock       (clock),
      .reset       (reset),
      .rsp_chan    (rsp_chan),
      .cmd_result  (cmd_result),
      .cmd_load    (cmd_load),
      .get_job     (get_job),
      .stat_now    (stat_now),
      .out_ctl     (out_ctl),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

endmodule
